### rtl/qsip_pkg.sv
`default_nettype none
package qsip_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned POS_W = 6;

	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_POP,
		S_LOOP,
		S_PV_A,
		S_PV_B,
		S_PV_C,
		S_LO_CHK,
		S_LO_A,
		S_LO_B,
		S_LO_C,
		S_HI_CHK,
		S_HI_A,
		S_HI_B,
		S_HI_C,
		S_SW_CHK,
		S_SW1,
		S_SW2,
		S_DO_CHK,
		S_PEND,
		S_OUT_A,
		S_OUT_B,
		S_OUT_C
	} state_t;

endpackage
`default_nettype wire

### rtl/quicksort_index_permutation.sv
// Index sort of a set of up to MAX_KEYS 32-bit keys.
// Keys arrive on the s_ channel, one per transfer, in load order; the transfer
// with s_tlast high closes the set. Keys beyond MAX_KEYS are dropped. The block
// then sorts by Hoare quicksort (middle element as pivot, larger part pushed on
// a range stack of STACK_DEPTH entries) and returns, on the m_ channel, the
// original load positions in ascending key order, m_tlast on the final one.
// Loading accepts one key per cycle. Sorting runs through one shared key
// comparator, one element at a time: an index memory read, a key memory
// read, a compare and a bound check, plus a swap done as two writes on the
// single write port of the index memory. The index memory is first filled
// with the load positions. Each result is read from the memories only after
// the previous one has been transferred. s_tready is low from the closing
// transfer until the last result transfer. A stalled receiver simply holds the
// result register; nothing is lost. compare_signed is written on the cfg_
// channel (always ready) and selects signed or unsigned compare. Reset clears
// the load count, stack pointer and state; compare_signed returns to 1.
`default_nettype none
module quicksort_index_permutation #(
	parameter int unsigned MAX_KEYS    = 64,
	parameter int unsigned STACK_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] key
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,   // [5:0] position, [7:6] zero
	output logic             m_tlast,   // final_res
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data   // compare_signed
);

	localparam int unsigned AW = $clog2(MAX_KEYS);
	localparam int unsigned CW = $clog2(MAX_KEYS + 1);
	localparam int unsigned SW = AW + 2;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IW = $clog2(STACK_DEPTH);

	qsip_pkg::state_t state_q, state_d;

	logic                 cs_q;
	logic [CW-1:0]        load_cnt_q;
	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        sp_q;
	logic [AW-1:0]        stk_l_q [STACK_DEPTH];
	logic [AW-1:0]        stk_r_q [STACK_DEPTH];
	logic signed [SW-1:0] left_q, right_q, lo_q, hi_q;
	logic [31:0]          pv_q;
	logic [AW-1:0]        ilo_q, ihi_q;
	logic                 out_vld_q;
	logic [AW-1:0]        out_pos_q;
	logic                 out_last_q;

	logic                 key_we;
	logic [AW-1:0]        key_waddr;
	logic [31:0]          key_rdata;
	logic                 idx_we;
	logic [AW-1:0]        idx_waddr, idx_wdata, idx_raddr, idx_rdata;
	logic signed [SW-1:0] mid;
	logic                 in_xfer, out_xfer;
	logic [PW-1:0]        sp_m1;
	logic signed [SW-1:0] push_a, push_b;
	logic                 push_lower;
	qsip_pkg::cmp_res_t   cmp;

	assign s_tready  = (state_q == qsip_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid & s_tready;
	assign out_xfer  = out_vld_q & m_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {2'b00, qsip_pkg::POS_W'(out_pos_q)};
	assign m_tlast   = out_last_q;
	assign mid       = (left_q + right_q) >>> 1;
	assign sp_m1     = sp_q - PW'(1);
	// The part holding more elements goes on the stack.
	assign push_lower = (lo_q - left_q) > (right_q - lo_q);
	assign push_a     = push_lower ? left_q : lo_q;
	assign push_b     = push_lower ? hi_q : right_q;

	qsip_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (s_tdata),
		.raddr (idx_rdata),
		.rdata (key_rdata)
	);

	qsip_ram #(.WIDTH(AW), .DEPTH(MAX_KEYS)) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (idx_raddr),
		.rdata (idx_rdata)
	);

	qsip_cmp u_cmp (
		.a         (key_rdata),
		.b         (pv_q),
		.is_signed (cs_q),
		.res       (cmp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qsip_pkg::S_IDLE: begin
				if (in_xfer && s_tlast) state_d = qsip_pkg::S_INIT;
			end
			qsip_pkg::S_INIT: begin
				if (cnt_q == load_cnt_q) state_d = qsip_pkg::S_POP;
			end
			qsip_pkg::S_POP: begin
				state_d = (sp_q == '0) ? qsip_pkg::S_OUT_A : qsip_pkg::S_LOOP;
			end
			qsip_pkg::S_LOOP: begin
				state_d = (left_q < right_q) ? qsip_pkg::S_PV_A : qsip_pkg::S_POP;
			end
			qsip_pkg::S_PV_A: state_d = qsip_pkg::S_PV_B;
			qsip_pkg::S_PV_B: state_d = qsip_pkg::S_PV_C;
			qsip_pkg::S_PV_C: state_d = qsip_pkg::S_LO_CHK;
			qsip_pkg::S_LO_CHK: begin
				state_d = (lo_q <= right_q) ? qsip_pkg::S_LO_A : qsip_pkg::S_HI_CHK;
			end
			qsip_pkg::S_LO_A: state_d = qsip_pkg::S_LO_B;
			qsip_pkg::S_LO_B: state_d = qsip_pkg::S_LO_C;
			qsip_pkg::S_LO_C: begin
				state_d = cmp.lt ? qsip_pkg::S_LO_CHK : qsip_pkg::S_HI_CHK;
			end
			qsip_pkg::S_HI_CHK: begin
				state_d = (hi_q >= left_q) ? qsip_pkg::S_HI_A : qsip_pkg::S_SW_CHK;
			end
			qsip_pkg::S_HI_A: state_d = qsip_pkg::S_HI_B;
			qsip_pkg::S_HI_B: state_d = qsip_pkg::S_HI_C;
			qsip_pkg::S_HI_C: begin
				state_d = cmp.gt ? qsip_pkg::S_HI_CHK : qsip_pkg::S_SW_CHK;
			end
			qsip_pkg::S_SW_CHK: begin
				state_d = (lo_q <= hi_q) ? qsip_pkg::S_SW1 : qsip_pkg::S_DO_CHK;
			end
			qsip_pkg::S_SW1: state_d = qsip_pkg::S_SW2;
			qsip_pkg::S_SW2: state_d = qsip_pkg::S_DO_CHK;
			qsip_pkg::S_DO_CHK: begin
				state_d = (hi_q >= lo_q) ? qsip_pkg::S_LO_CHK : qsip_pkg::S_PEND;
			end
			qsip_pkg::S_PEND: state_d = qsip_pkg::S_LOOP;
			qsip_pkg::S_OUT_A: state_d = qsip_pkg::S_OUT_B;
			qsip_pkg::S_OUT_B: state_d = qsip_pkg::S_OUT_C;
			qsip_pkg::S_OUT_C: begin
				if (out_xfer) begin
					state_d = out_last_q ? qsip_pkg::S_IDLE : qsip_pkg::S_OUT_A;
				end
			end
			default: state_d = qsip_pkg::S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		key_we    = in_xfer && (load_cnt_q < CW'(MAX_KEYS));
		key_waddr = load_cnt_q[AW-1:0];
		idx_we    = 1'b0;
		idx_waddr = cnt_q[AW-1:0];
		idx_wdata = cnt_q[AW-1:0];
		idx_raddr = lo_q[AW-1:0];
		unique case (state_q)
			qsip_pkg::S_INIT: idx_we = (cnt_q != load_cnt_q);
			qsip_pkg::S_PV_A: idx_raddr = mid[AW-1:0];
			qsip_pkg::S_HI_A: idx_raddr = hi_q[AW-1:0];
			qsip_pkg::S_OUT_A: idx_raddr = cnt_q[AW-1:0];
			qsip_pkg::S_SW1: begin
				idx_we    = 1'b1;
				idx_waddr = hi_q[AW-1:0];
				idx_wdata = ilo_q;
			end
			qsip_pkg::S_SW2: begin
				idx_we    = 1'b1;
				idx_waddr = lo_q[AW-1:0];
				idx_wdata = ihi_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= qsip_pkg::S_IDLE;
			cs_q       <= 1'b1;
			load_cnt_q <= '0;
			cnt_q      <= '0;
			sp_q       <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cs_q <= cfg_data;
			if (key_we) load_cnt_q <= load_cnt_q + CW'(1);
			unique case (state_q)
				qsip_pkg::S_IDLE: cnt_q <= '0;
				qsip_pkg::S_INIT: begin
					if (cnt_q != load_cnt_q) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						sp_q <= (load_cnt_q > CW'(1)) ? PW'(1) : '0;
					end
				end
				qsip_pkg::S_POP: begin
					cnt_q <= '0;
					if (sp_q != '0) sp_q <= sp_m1;
				end
				qsip_pkg::S_PEND: begin
					if ((push_a < push_b) && (sp_q < PW'(STACK_DEPTH))) begin
						sp_q <= sp_q + PW'(1);
					end
				end
				qsip_pkg::S_OUT_B: out_vld_q <= 1'b1;
				qsip_pkg::S_OUT_C: begin
					if (out_xfer) begin
						out_vld_q <= 1'b0;
						cnt_q     <= cnt_q + CW'(1);
						if (out_last_q) begin
							load_cnt_q <= '0;
							sp_q       <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			qsip_pkg::S_INIT: begin
				if (cnt_q == load_cnt_q) begin
					stk_l_q[0] <= '0;
					stk_r_q[0] <= AW'(load_cnt_q - CW'(1));
				end
			end
			qsip_pkg::S_POP: begin
				left_q  <= $signed({2'b00, stk_l_q[sp_m1[IW-1:0]]});
				right_q <= $signed({2'b00, stk_r_q[sp_m1[IW-1:0]]});
			end
			qsip_pkg::S_PV_C: begin
				pv_q <= key_rdata;
				lo_q <= left_q;
				hi_q <= right_q;
			end
			qsip_pkg::S_LO_B: ilo_q <= idx_rdata;
			qsip_pkg::S_LO_C: if (cmp.lt) lo_q <= lo_q + SW'(1);
			qsip_pkg::S_HI_B: ihi_q <= idx_rdata;
			qsip_pkg::S_HI_C: if (cmp.gt) hi_q <= hi_q - SW'(1);
			qsip_pkg::S_SW2: begin
				lo_q <= lo_q + SW'(1);
				hi_q <= hi_q - SW'(1);
			end
			qsip_pkg::S_PEND: begin
				if ((push_a < push_b) && (sp_q < PW'(STACK_DEPTH))) begin
					stk_l_q[sp_q[IW-1:0]] <= push_a[AW-1:0];
					stk_r_q[sp_q[IW-1:0]] <= push_b[AW-1:0];
				end
				if (push_lower) left_q <= lo_q;
				else right_q <= hi_q;
			end
			qsip_pkg::S_OUT_B: begin
				out_pos_q  <= idx_rdata;
				out_last_q <= (cnt_q + CW'(1)) == load_cnt_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### rtl/qsip_ram.sv
`default_nettype none
module qsip_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/qsip_cmp.sv
`default_nettype none
module qsip_cmp (
	input  wire logic [qsip_pkg::KEY_W-1:0] a,
	input  wire logic [qsip_pkg::KEY_W-1:0] b,
	input  wire logic                        is_signed,
	output qsip_pkg::cmp_res_t               res
);

	logic [qsip_pkg::KEY_W-1:0] oa;
	logic [qsip_pkg::KEY_W-1:0] ob;

	// Flipping the sign bit maps two's complement order onto unsigned order.
	always_comb begin
		oa = {a[qsip_pkg::KEY_W-1] ^ is_signed, a[qsip_pkg::KEY_W-2:0]};
		ob = {b[qsip_pkg::KEY_W-1] ^ is_signed, b[qsip_pkg::KEY_W-2:0]};
		res.lt = oa < ob;
		res.gt = oa > ob;
	end

endmodule
`default_nettype wire
